@@ design/quoted_printable_decoder_top_assert.svh @@
// ----------------------------------------------------------------------------
// Quoted-printable decoder assertion macros
// Shared property wrappers, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef QUOTED_PRINTABLE_DECODER_TOP_ASSERT_SVH
`define QUOTED_PRINTABLE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define QPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qpd assertion failed");

// Next-cycle implication.
`define QPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qpd assertion failed");

`endif

@@ design/qpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Quoted-printable decoder package
// Character codes, escape phase type, batch types and hex helpers.
// ----------------------------------------------------------------------------
package qpd_pkg;

  localparam int CountWidth    = 16;
  localparam int OutCountWidth = 16;
  localparam int MaxResults    = 3;

  localparam logic [7:0] CharEq  = 8'h3D;
  localparam logic [7:0] CharLf  = 8'h0A;
  localparam logic [7:0] Char0   = 8'h30;
  localparam logic [7:0] Char9   = 8'h39;
  localparam logic [7:0] CharLa  = 8'h61;
  localparam logic [7:0] CharLf2 = 8'h66;
  localparam logic [7:0] CharUa  = 8'h41;
  localparam logic [7:0] CharUf  = 8'h46;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhEq    = 2'd1,
    PhDigit = 2'd2
  } qpd_phase_e;

  // Results caused by one request, in output order.
  typedef struct packed {
    logic [1:0]                       num;
    logic [MaxResults-1:0][7:0]       bytes;
    logic                             has_byte;
    logic                             last;
  } qpd_batch_t;

  typedef struct packed {
    qpd_batch_t  batch;
    qpd_phase_e  phase;
    logic [7:0]  held;
  } qpd_dec_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= Char0) && (c <= Char9)) || ((c >= CharLa) && (c <= CharLf2)) ||
           ((c >= CharUa) && (c <= CharUf));
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if ((c >= Char0) && (c <= Char9)) begin
      v = c - Char0;
    end else if ((c >= CharLa) && (c <= CharLf2)) begin
      v = c - CharLa + 8'd10;
    end else if ((c >= CharUa) && (c <= CharUf)) begin
      v = c - CharUa + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

@@ design/qpd_decode.sv @@
// ----------------------------------------------------------------------------
// Quoted-printable decode logic
// Maps escape state and one input byte to up to three results and the
// next escape state.
// ----------------------------------------------------------------------------
module qpd_decode (
  input  qpd_pkg::qpd_phase_e phase_i,
  input  logic [7:0]          held_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_i,
  output qpd_pkg::qpd_dec_t   dec_o
);
  import qpd_pkg::*;

  function automatic qpd_batch_t push(input qpd_batch_t b, input logic [7:0] c);
    qpd_batch_t r;
    r = b;
    if (b.num != 2'd3) begin
      r.bytes[b.num] = c;
      r.num          = b.num + 2'd1;
    end
    return r;
  endfunction

  always_comb begin
    qpd_batch_t bt;
    qpd_phase_e np;
    logic [7:0] nh;
    bt          = '0;
    bt.has_byte = 1'b1;
    np          = PhIdle;
    nh          = held_i;

    unique case (phase_i)
      PhEq: begin
        if (data_byte_i == CharLf) begin
          np = PhIdle;  // soft break, drop both
        end else if (is_hex(data_byte_i)) begin
          np = PhDigit;
          nh = data_byte_i;
        end else begin
          bt = push(bt, CharEq);
          if (data_byte_i == CharEq) np = PhEq;
          else bt = push(bt, data_byte_i);
        end
      end
      PhDigit: begin
        if (is_hex(held_i) && is_hex(data_byte_i)) begin
          bt = push(bt, {nibble(held_i), nibble(data_byte_i)});
        end else begin
          bt = push(bt, CharEq);
          bt = push(bt, held_i);
          if (data_byte_i == CharEq) np = PhEq;
          else bt = push(bt, data_byte_i);
        end
      end
      default: begin
        if (data_byte_i == CharEq) np = PhEq;
        else bt = push(bt, data_byte_i);
      end
    endcase

    if (last_i) begin
      // flush a pending escape as literal bytes
      if (np == PhEq) begin
        bt = push(bt, CharEq);
      end else if (np == PhDigit) begin
        bt = push(bt, CharEq);
        bt = push(bt, nh);
      end
      if (bt.num == 2'd0) begin
        bt.num      = 2'd1;
        bt.has_byte = 1'b0;
      end
      bt.last = 1'b1;
      np      = PhIdle;
      nh      = 8'd0;
    end

    dec_o.batch = bt;
    dec_o.phase = np;
    dec_o.held  = nh;
  end

endmodule

@@ design/qpd_emit.sv @@
// ----------------------------------------------------------------------------
// Quoted-printable result emitter
// Holds one batch of results and shifts them out through the output register
// one per cycle unless stalled, tagging each with the saturating byte count.
// ----------------------------------------------------------------------------
module qpd_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  qpd_pkg::qpd_batch_t           batch_i,
  output logic                          push_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          has_byte_o,
  output logic [7:0]                    out_byte_o,
  output logic                          out_last_o,
  output logic [qpd_pkg::OutCountWidth-1:0] out_count_o
);
  import qpd_pkg::*;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  logic                  b_valid_q;
  qpd_batch_t            b_q;
  logic [1:0]            b_idx_q;
  logic                  o_valid_q;
  logic                  o_has_q;
  logic [7:0]            o_byte_q;
  logic                  o_last_q;
  logic [OutCountWidth-1:0] o_count_q;
  logic [CountWidth-1:0] cnt_q;
  logic [CountWidth-1:0] cnt_d;
  logic [CountWidth-1:0] cnt_val;

  logic o_free;
  logic load;
  logic at_end;
  logic b_done;
  logic entry_last;

  assign o_free     = !o_valid_q || out_ready_i;
  assign load       = b_valid_q && o_free;
  assign at_end     = (b_idx_q == (b_q.num - 2'd1));
  assign b_done     = load && at_end;
  assign entry_last = b_q.last && at_end;

  assign push_ready_o = !b_valid_q || b_done;

  // Count the byte being loaded; markers leave it as is.
  assign cnt_val = (b_q.has_byte && (cnt_q != CountMax)) ? cnt_q + CountWidth'(1) : cnt_q;
  assign cnt_d   = entry_last ? '0 : cnt_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_idx_q   <= 2'd0;
      o_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (push_i) begin
        b_valid_q <= 1'b1;
        b_idx_q   <= 2'd0;
      end else if (b_done) begin
        b_valid_q <= 1'b0;
      end else if (load) begin
        b_idx_q <= b_idx_q + 2'd1;
      end
      if (load) begin
        o_valid_q <= 1'b1;
        cnt_q     <= cnt_d;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      b_q <= batch_i;
    end
    if (load) begin
      o_has_q   <= b_q.has_byte;
      o_byte_q  <= b_q.has_byte ? b_q.bytes[b_idx_q] : 8'd0;
      o_last_q  <= entry_last;
      o_count_q <= OutCountWidth'(cnt_val);
    end
  end

  assign out_valid_o = o_valid_q;
  assign has_byte_o  = o_has_q;
  assign out_byte_o  = o_byte_q;
  assign out_last_o  = o_last_q;
  assign out_count_o = o_count_q;

endmodule

@@ design/quoted_printable_decoder_top.sv @@
// An accepted request goes to the batch register; its first result then moves on to
// the output register when that is free, and can be taken from there. Throughput: one
// request per cycle while the output is taken and each yields at most one result;
// a request yielding k results (k up to 3) holds the batch register until all k are
// loaded; the result stage (a batch register feeding an output register) sets the rate.
// Reset (rst_ni low, asynchronous) clears escape state, byte count and valids.
// ----------------------------------------------------------------------------
// Quoted-printable decoder top level
// Escape state registers, decode logic and result emitter.
// ----------------------------------------------------------------------------
`include "quoted_printable_decoder_top_assert.svh"

module quoted_printable_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        has_byte_o,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [qpd_pkg::OutCountWidth-1:0] out_count_o
);
  import qpd_pkg::*;

  qpd_phase_e phase_q;
  logic [7:0] held_q;
  qpd_dec_t   dec;
  logic       accept;
  logic       push;

  qpd_decode u_decode (
    .phase_i     (phase_q),
    .held_i      (held_q),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .dec_o       (dec)
  );

  assign accept = in_valid_i && in_ready_o;
  assign push   = accept && (dec.batch.num != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= 8'd0;
    end else if (accept) begin
      phase_q <= dec.phase;
      held_q  <= dec.held;
    end
  end

  qpd_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .batch_i      (dec.batch),
    .push_ready_o (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .has_byte_o   (has_byte_o),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .out_count_o  (out_count_o)
  );

  `QPD_ASSERT_NOW(a_marker_is_last, out_valid_o && !has_byte_o, out_last_o)
  `QPD_ASSERT_NOW(a_byte_counted, out_valid_o && has_byte_o, out_count_o != '0)
  `QPD_ASSERT_NEXT(a_last_clears_phase, accept && last_i, phase_q == PhIdle)

endmodule

@@ verif/quoted_printable_decoder_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quoted-printable decoder testbench
// Streams encoded text through the decoder with random gaps on both sides and
// checks every decoded byte, end marker and count against an internal decoder.
// ----------------------------------------------------------------------------
module quoted_printable_decoder_top_tb;
  import qpd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } qp_request_t;

  typedef struct packed {
    logic                     has_byte;
    logic [7:0]               data;
    logic                     last;
    logic [OutCountWidth-1:0] count;
  } qp_result_t;

  localparam int StallLen = 300;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_i      = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        has_byte_o;
  logic [7:0]  out_byte_o;
  logic        out_last_o;
  logic [OutCountWidth-1:0] out_count_o;

  qp_request_t pending_requests[$];
  qp_result_t  expected_results[$];
  qp_result_t  step_results[$];

  // Decoder state as the block should hold it
  qpd_phase_e            esc_phase   = PhIdle;
  logic [7:0]            first_digit = 8'd0;
  logic [CountWidth-1:0] byte_count  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int stall_seq      = 0;
  int stall_seen     = 0;
  int stall_left     = 0;

  quoted_printable_decoder_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .has_byte_o  (has_byte_o),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .out_count_o (out_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic int digit_val(input logic [7:0] c);
    if (c >= Char0 && c <= Char9) return int'(c - Char0);
    if (c >= CharLa && c <= CharLf2) return int'(c - CharLa) + 10;
    if (c >= CharUa && c <= CharUf) return int'(c - CharUa) + 10;
    return -1;
  endfunction

  // At most MaxResults bytes per request; a dropped byte does not count
  function automatic void emit_byte(input logic [7:0] b);
    qp_result_t r;
    if (step_results.size() < MaxResults) begin
      if (byte_count != '1) byte_count++;
      r.has_byte = 1'b1;
      r.data     = b;
      r.last     = 1'b0;
      r.count    = byte_count[OutCountWidth-1:0];
      step_results.push_back(r);
    end
  endfunction

  function automatic void take_plain(input logic [7:0] b);
    if (b == CharEq) esc_phase = PhEq;
    else emit_byte(b);
  endfunction

  function automatic void decode_request(input logic [7:0] b, input logic is_last);
    int hi;
    int lo;
    qp_result_t marker;
    step_results.delete();
    case (esc_phase)
      PhEq: begin
        if (b == CharLf) begin
          esc_phase = PhIdle;
        end else if (digit_val(b) >= 0) begin
          first_digit = b;
          esc_phase = PhDigit;
        end else begin
          esc_phase = PhIdle;
          emit_byte(CharEq);
          take_plain(b);
        end
      end
      PhDigit: begin
        hi = digit_val(first_digit);
        lo = digit_val(b);
        esc_phase = PhIdle;
        if (hi >= 0 && lo >= 0) begin
          emit_byte(8'(hi * 16 + lo));
        end else begin
          emit_byte(CharEq);
          emit_byte(first_digit);
          take_plain(b);
        end
      end
      default: begin
        esc_phase = PhIdle;
        take_plain(b);
      end
    endcase
    if (is_last) begin
      // flush a pending escape as literal bytes
      if (esc_phase == PhEq) begin
        emit_byte(CharEq);
      end else if (esc_phase == PhDigit) begin
        emit_byte(CharEq);
        emit_byte(first_digit);
      end
      if (step_results.size() == 0) begin
        marker.has_byte = 1'b0;
        marker.data     = 8'd0;
        marker.last     = 1'b1;
        marker.count    = byte_count[OutCountWidth-1:0];
        step_results.push_back(marker);
      end else begin
        step_results[step_results.size()-1].last = 1'b1;
      end
      esc_phase   = PhIdle;
      first_digit = 8'd0;
      byte_count  = '0;
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_blk
    qp_request_t req;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= 8'd0;
      last_i      <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) decode_request(data_byte_i, last_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req = pending_requests.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= req.data;
          last_i      <= req.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by bumping stall_seq
  always @(posedge clk_i) begin
    if (stall_seq != stall_seen) begin
      stall_left <= StallLen;
      stall_seen <= stall_seq;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin : monitor_blk
    qp_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte=%02h last=%0b count=%0d",
                                    out_byte_o, out_last_o, out_count_o));
        end else begin
          want = expected_results.pop_front();
          if (has_byte_o !== want.has_byte)
            report_mismatch($sformatf("has_byte %0b, expected %0b", has_byte_o, want.has_byte));
          if (out_byte_o !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte_o, want.data));
          if (out_last_o !== want.last)
            report_mismatch($sformatf("out_last %0b, expected %0b", out_last_o, want.last));
          if (out_count_o !== want.count)
            report_mismatch($sformatf("out_count %0d, expected %0d", out_count_o, want.count));
        end
      end
      out_ready_i <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic void push_req(input logic [7:0] b, input logic is_last);
    qp_request_t req;
    req.data = b;
    req.last = is_last;
    pending_requests.push_back(req);
  endfunction

  // Hold until every request is sent and every result is back
  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return Char0 + 8'(v);
    if (v < 16) return CharLa + 8'(v - 10);
    return CharUa + 8'(v - 16);
  endfunction

  function automatic logic [7:0] rand_non_hex(input logic allow_lf);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (digit_val(b) >= 0 || (!allow_lf && b == CharLf));
    return b;
  endfunction

  // Queue one text of mostly well-formed escapes; return its length
  function automatic int push_text();
    logic [7:0] text_q[$];
    int pieces;
    int sel;
    pieces = $urandom_range(1, 8);
    if ($urandom_range(0, 9) == 0) begin
      repeat (pieces) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (pieces) begin
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end else if (sel < 65) begin
          text_q.push_back(CharEq);
          text_q.push_back(rand_hex());
          text_q.push_back(rand_hex());
        end else if (sel < 75) begin
          text_q.push_back(CharEq);
          text_q.push_back(CharLf);
        end else if (sel < 83) begin
          text_q.push_back(CharEq);
          text_q.push_back(rand_hex());
          text_q.push_back(rand_non_hex(1'b1));
        end else if (sel < 91) begin
          text_q.push_back(CharEq);
          text_q.push_back(rand_non_hex(1'b0));
        end else if (sel < 96) begin
          text_q.push_back(CharEq);
        end else begin
          text_q.push_back(CharEq);
          text_q.push_back(rand_hex());
        end
      end
    end
    foreach (text_q[i]) push_req(text_q[i], i == text_q.size() - 1);
    return text_q.size();
  endfunction

  initial begin
    #20_000_000;
    $display("quoted_printable_decoder_top test failed");
    $finish;
  end

  initial begin : stim_blk
    int sent;
    int idle_tab[4];
    int stall_tab[4];
    idle_tab  = '{0, 51, 0, 35};
    stall_tab = '{0, 0, 51, 35};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // plain extremes
    push_req(8'h00, 1'b0);
    push_req(8'hFF, 1'b1);
    // hex escapes in both cases
    push_req(CharEq, 1'b0);
    push_req(8'h34, 1'b0);
    push_req(8'h61, 1'b0);
    push_req(CharEq, 1'b0);
    push_req(8'h46, 1'b0);
    push_req(8'h66, 1'b1);
    // soft break, then a bare line feed
    push_req(CharEq, 1'b0);
    push_req(CharLf, 1'b0);
    push_req(CharLf, 1'b1);
    // escape cut right after the equals sign
    push_req(CharEq, 1'b0);
    push_req(8'h47, 1'b1);
    // escape cut by a second equals sign that opens a new one
    push_req(CharEq, 1'b0);
    push_req(CharEq, 1'b0);
    push_req(8'h34, 1'b0);
    push_req(8'h31, 1'b1);
    // escape cut after one digit, three bytes out of one request
    push_req(CharEq, 1'b0);
    push_req(8'h34, 1'b0);
    push_req(8'h7A, 1'b1);
    // cut after one digit by an equals sign that is then flushed
    push_req(CharEq, 1'b0);
    push_req(8'h39, 1'b0);
    push_req(CharEq, 1'b1);
    // lone equals sign at the end, held digit at the end
    push_req(CharEq, 1'b1);
    push_req(CharEq, 1'b0);
    push_req(8'h41, 1'b1);
    // nothing to give at the end: end-only marker
    push_req(CharEq, 1'b0);
    push_req(CharLf, 1'b1);
    wait_idle();

    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = idle_tab[m];
      recv_stall_pct = stall_tab[m];
      sent = 0;
      while (sent < 60) begin
        sent += push_text();
        // fill the block while the receiver holds off
        if (m == 0 && sent >= 40 && stall_seq == 0) begin
          @(negedge clk_i);
          stall_seq++;
        end
        // let the sender pause until every result is back
        if (m == 1 && $urandom_range(0, 3) == 0) wait_idle();
      end
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (fail_count == 0) begin
      $display("quoted_printable_decoder_top test passed");
    end else begin
      $display("quoted_printable_decoder_top test failed");
    end
    $finish;
  end

endmodule
